/* rtl/mti_pkg.sv */
// mti_pkg: shared types, codes and helpers of the monotone table interpolator
// depends on nothing; used by mti_muldiv, the core, mti_checker and the testbench
`default_nettype none
package mti_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W       = 5;
	localparam int CFG_DATA_W  = 5;
	localparam int DIFF_W      = DATA_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int STEP_W      = $clog2(PROD_W);
	localparam int CAP_LOG     = 40;
	localparam int QUOT_W      = CAP_LOG + 1;
	localparam int SQ_W        = QUOT_W + 1;
	localparam int SUM_W       = SQ_W + 1;

	localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {(QUOT_W-1){1'b0}}};
	localparam logic signed [DIFF_W-1:0] ONE_Q = DIFF_W'(64'd1 << FRAC_BITS);

	localparam logic [2:0] FUNC_LOAD      = 3'd0;
	localparam logic [2:0] FUNC_FWD       = 3'd1;
	localparam logic [2:0] FUNC_REV       = 3'd2;
	localparam logic [2:0] FUNC_FWD_SLOPE = 3'd3;
	localparam logic [2:0] FUNC_REV_SLOPE = 3'd4;
	localparam logic [2:0] FUNC_CHECK     = 3'd5;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOT_MONO = 2'd1;
	localparam logic [1:0] STAT_NOT_REV  = 2'd2;
	localparam logic [1:0] STAT_PROP     = 2'd3;

	localparam logic [1:0] PROP_POS      = 2'd0;
	localparam logic [1:0] PROP_NONNEG   = 2'd1;
	localparam logic [1:0] PROP_STRICT   = 2'd2;
	localparam logic [1:0] PROP_SLOPE_UP = 2'd3;

	localparam logic CFG_ENTRIES = 1'b0;
	localparam logic CFG_MODE    = 1'b1;

	typedef struct packed {
		logic [2:0]               func;
		logic [3:0]               entry_index;
		logic signed [DATA_W-1:0] x_value;
		logic signed [DATA_W-1:0] y_value;
		logic signed [DATA_W-1:0] query_value;
		logic [1:0]               property_req;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [1:0]               status;
	} out_item_t;

	function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = {{(SUM_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
		lo = {{(SUM_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};
		if (v > hi)
			sat_word = hi[DATA_W-1:0];
		else if (v < lo)
			sat_word = lo[DATA_W-1:0];
		else
			sat_word = v[DATA_W-1:0];
	endfunction

	function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		sdiff = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
	endfunction

endpackage
`default_nettype wire

/* rtl/mti_muldiv.sv */
// mti_muldiv: serial multiply then restoring divide, a*b/d rounded, capped
// depends on mti_pkg
`default_nettype none
module mti_muldiv (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [mti_pkg::DIFF_W-1:0]  a,
	input  wire logic signed [mti_pkg::DIFF_W-1:0]  b,
	input  wire logic signed [mti_pkg::DIFF_W-1:0]  d,
	output logic                                     busy,
	output logic                                     done,
	output logic signed [mti_pkg::SQ_W-1:0]         quot
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;
	localparam logic [1:0] P_RND  = 2'd3;

	logic [1:0]                        phase_q;
	logic [mti_pkg::PROD_W-1:0]        mcand_q;
	logic [mti_pkg::DIFF_W-1:0]        mplier_q;
	logic [mti_pkg::PROD_W-1:0]        acc_q;
	logic [mti_pkg::DIFF_W-1:0]        ud_q;
	logic [mti_pkg::DIFF_W-1:0]        r_q;
	logic [mti_pkg::QUOT_W-1:0]        quo_q;
	logic                              neg_q;
	logic [mti_pkg::STEP_W-1:0]        cnt_q;
	logic                              done_q;
	logic signed [mti_pkg::SQ_W-1:0]   quot_q;

	logic [mti_pkg::DIFF_W-1:0]        ua, ub, ud;
	logic                              neg;
	logic [mti_pkg::DIFF_W:0]          rs;
	logic                              ge;
	logic [mti_pkg::QUOT_W-1:0]        qn;
	logic [mti_pkg::QUOT_W-1:0]        qr;

	always_comb begin
		ua  = mti_pkg::mag(a);
		ub  = mti_pkg::mag(b);
		ud  = mti_pkg::mag(d);
		neg = (a[mti_pkg::DIFF_W-1] ^ b[mti_pkg::DIFF_W-1]) ^ d[mti_pkg::DIFF_W-1];
		rs  = {r_q, acc_q[mti_pkg::PROD_W-1]};
		ge  = rs >= {1'b0, ud_q};
		qn  = quo_q;
		if (quo_q < mti_pkg::QUOT_CAP)
			qn = {quo_q[mti_pkg::QUOT_W-2:0], ge};
		if (qn > mti_pkg::QUOT_CAP)
			qn = mti_pkg::QUOT_CAP;
		qr = quo_q;
		if (quo_q < mti_pkg::QUOT_CAP && {r_q, 1'b0} >= {1'b0, ud_q})
			qr = quo_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						if (ua == '0 || ub == '0) begin
							quot_q <= '0;
							done_q <= 1'b1;
						end else if (ud == '0) begin
							quot_q <= neg ? -$signed({1'b0, mti_pkg::QUOT_CAP})
								: $signed({1'b0, mti_pkg::QUOT_CAP});
							done_q <= 1'b1;
						end else begin
							phase_q  <= P_MUL;
							mcand_q  <= mti_pkg::PROD_W'(ua);
							mplier_q <= ub;
							acc_q    <= '0;
							ud_q     <= ud;
							neg_q    <= neg;
							cnt_q    <= '0;
							r_q      <= '0;
							quo_q    <= '0;
						end
					end
				end
				P_MUL: begin
					if (mplier_q[0])
						acc_q <= acc_q + mcand_q;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == mti_pkg::STEP_W'(mti_pkg::DIFF_W - 1)) begin
						cnt_q   <= '0;
						phase_q <= P_DIV;
					end
				end
				P_DIV: begin
					acc_q <= acc_q << 1;
					r_q   <= ge ? mti_pkg::DIFF_W'(rs - {1'b0, ud_q})
						: rs[mti_pkg::DIFF_W-1:0];
					quo_q <= qn;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == mti_pkg::STEP_W'(mti_pkg::PROD_W - 1))
						phase_q <= P_RND;
				end
				P_RND: begin
					quot_q  <= neg_q ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
					done_q  <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	assign busy = phase_q != P_IDLE;
	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

/* rtl/monotone_table_interpolator_core.sv */
// monotone_table_interpolator_core: breakpoint table, search sequencer, output register
// in linear mode a query runs a binary search, then the shared multiply/divide
// unit; slope check repeats that unit once per segment
// one item at a time; in_ready only while the sequencer is idle
// reset: flags set, entries_in_use 2, linear mode; table contents undefined
// depends on mti_pkg and mti_muldiv
`default_nettype none
module monotone_table_interpolator_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire mti_pkg::in_item_t   in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output mti_pkg::out_item_t       out_item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [mti_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LD   = 4'd1;
	localparam logic [3:0] ST_SR   = 4'd2;
	localparam logic [3:0] ST_SRC  = 4'd3;
	localparam logic [3:0] ST_NXT  = 4'd4;
	localparam logic [3:0] ST_GL   = 4'd5;
	localparam logic [3:0] ST_GU   = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_CKI  = 4'd8;
	localparam logic [3:0] ST_CKT  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	localparam int DW = mti_pkg::DATA_W;
	localparam int IW = mti_pkg::IDX_W;

	logic [3:0]                  state_q;
	mti_pkg::in_item_t           item_q;
	logic [mti_pkg::ENT_W-1:0]   ent_q;
	logic                        mode_q;
	logic                        mono_q, strict_q;
	logic                        rev_q, slope_q, chk_q, first_q;
	logic [IW-1:0]               jl_q, ju_q, jm_q, ci_q;
	logic signed [DW-1:0]        lo_k_q, lo_o_q, s_q, res_q;
	logic [1:0]                  stat_q;
	logic                        out_valid_q;
	mti_pkg::out_item_t          out_q;

	logic signed [DW-1:0]        x_mem [mti_pkg::TABLE_DEPTH];
	logic signed [DW-1:0]        y_mem [mti_pkg::TABLE_DEPTH];
	logic signed [DW-1:0]        rd_x_q, rd_y_q;
	logic                        we;
	logic [IW-1:0]               raddr_c;

	logic [mti_pkg::CNT_W-1:0]   n_c;
	logic [IW-1:0]               last_c;
	logic [IW:0]                 span_c, mid_c;
	logic signed [DW-1:0]        key_c, oval_c, val_c;
	logic                        ld_mono_c;
	logic                        div_start, div_busy, div_done;
	logic signed [mti_pkg::DIFF_W-1:0] div_a, div_b, div_d;
	logic signed [mti_pkg::SQ_W-1:0]   div_q;
	logic                        out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	assign we = in_valid && in_ready && in_item.func == mti_pkg::FUNC_LOAD
		&& 32'(in_item.entry_index) < mti_pkg::TABLE_DEPTH;

	always_comb begin
		if (ent_q < mti_pkg::ENT_W'(2))
			n_c = mti_pkg::CNT_W'(2);
		else if (32'(ent_q) > mti_pkg::TABLE_DEPTH)
			n_c = mti_pkg::CNT_W'(mti_pkg::TABLE_DEPTH);
		else
			n_c = mti_pkg::CNT_W'(ent_q);
		last_c = IW'(n_c - 1'b1);
		span_c = {1'b0, ju_q} - {1'b0, jl_q};
		mid_c  = ({1'b0, ju_q} + {1'b0, jl_q}) >> 1;
		key_c  = rev_q ? rd_y_q : rd_x_q;
		oval_c = rev_q ? rd_x_q : rd_y_q;
		ld_mono_c = mono_q && !(item_q.x_value <= rd_x_q || item_q.y_value < rd_y_q);
		val_c  = (chk_q || slope_q) ? mti_pkg::sat_word(mti_pkg::SUM_W'(div_q))
			: mti_pkg::sat_word(mti_pkg::SUM_W'(lo_o_q) + mti_pkg::SUM_W'(div_q));
		div_a  = mti_pkg::sdiff(oval_c, lo_o_q);
		div_b  = (slope_q || chk_q) ? mti_pkg::ONE_Q
			: mti_pkg::sdiff(item_q.query_value, lo_k_q);
		div_d  = mti_pkg::sdiff(key_c, lo_k_q);
		div_start = state_q == ST_GU && (chk_q || mode_q);
		raddr_c = jl_q;
		unique case (state_q)
			ST_IDLE: raddr_c = IW'(in_item.entry_index - 1'b1);
			ST_SR:   raddr_c = span_c > 1 ? IW'(mid_c) : jl_q;
			ST_GL:   raddr_c = ju_q;
			ST_CKI:  raddr_c = ci_q;
			default: raddr_c = jl_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			x_mem[IW'(in_item.entry_index)] <= in_item.x_value;
			y_mem[IW'(in_item.entry_index)] <= in_item.y_value;
		end
		rd_x_q <= x_mem[raddr_c];
		rd_y_q <= y_mem[raddr_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= mti_pkg::ENT_W'(2);
			mode_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mti_pkg::CFG_ENTRIES: ent_q <= mti_pkg::ENT_W'(cfg_data);
				mti_pkg::CFG_MODE:    mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mono_q      <= 1'b1;
			strict_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !(state_q == ST_DONE && out_free))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						res_q   <= '0;
						stat_q  <= mti_pkg::STAT_OK;
						rev_q   <= in_item.func == mti_pkg::FUNC_REV
							|| in_item.func == mti_pkg::FUNC_REV_SLOPE;
						slope_q <= in_item.func == mti_pkg::FUNC_FWD_SLOPE
							|| in_item.func == mti_pkg::FUNC_REV_SLOPE;
						chk_q   <= 1'b0;
						first_q <= 1'b1;
						jl_q    <= '0;
						ju_q    <= last_c;
						ci_q    <= IW'(1);
						state_q <= ST_DONE;
						case (in_item.func)
							mti_pkg::FUNC_LOAD: begin
								if (!we)
									stat_q <= mono_q ? mti_pkg::STAT_OK
										: mti_pkg::STAT_NOT_MONO;
								else if (in_item.entry_index == '0) begin
									mono_q   <= 1'b1;
									strict_q <= 1'b1;
								end else
									state_q <= ST_LD;
							end
							mti_pkg::FUNC_FWD, mti_pkg::FUNC_REV,
							mti_pkg::FUNC_FWD_SLOPE, mti_pkg::FUNC_REV_SLOPE: begin
								if (!mono_q)
									stat_q <= mti_pkg::STAT_NOT_MONO;
								else if ((in_item.func == mti_pkg::FUNC_REV
									|| in_item.func == mti_pkg::FUNC_REV_SLOPE) && !strict_q)
									stat_q <= mti_pkg::STAT_NOT_REV;
								else if (!((in_item.func == mti_pkg::FUNC_FWD_SLOPE
									|| in_item.func == mti_pkg::FUNC_REV_SLOPE) && !mode_q))
									state_q <= ST_SR;
							end
							mti_pkg::FUNC_CHECK: begin
								if (!mono_q)
									stat_q <= mti_pkg::STAT_NOT_MONO;
								else begin
									case (in_item.property_req)
										mti_pkg::PROP_STRICT:
											stat_q <= strict_q ? mti_pkg::STAT_OK
												: mti_pkg::STAT_PROP;
										mti_pkg::PROP_SLOPE_UP: begin
											rev_q   <= 1'b0;
											chk_q   <= 1'b1;
											ju_q    <= IW'(1);
											state_q <= ST_NXT;
										end
										default: state_q <= ST_CKI;
									endcase
								end
							end
							default: ;
						endcase
					end
				end
				ST_LD: begin
					mono_q <= ld_mono_c;
					if (item_q.y_value == rd_y_q)
						strict_q <= 1'b0;
					stat_q  <= ld_mono_c ? mti_pkg::STAT_OK : mti_pkg::STAT_NOT_MONO;
					state_q <= ST_DONE;
				end
				ST_SR: begin
					jm_q    <= IW'(mid_c);
					state_q <= span_c > 1 ? ST_SRC : ST_GL;
				end
				ST_SRC: begin
					if (item_q.query_value >= key_c)
						jl_q <= jm_q;
					else
						ju_q <= jm_q;
					state_q <= ST_SR;
				end
				ST_NXT: state_q <= ST_GL;
				ST_GL: begin
					lo_k_q  <= key_c;
					lo_o_q  <= oval_c;
					state_q <= ST_GU;
				end
				ST_GU: begin
					if (!chk_q && !mode_q) begin
						res_q   <= item_q.query_value < key_c ? lo_o_q : oval_c;
						state_q <= ST_DONE;
					end else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (!chk_q) begin
							res_q   <= val_c;
							state_q <= ST_DONE;
						end else if (!first_q && val_c < s_q) begin
							stat_q  <= mti_pkg::STAT_PROP;
							state_q <= ST_DONE;
						end else begin
							s_q     <= val_c;
							first_q <= 1'b0;
							if (ju_q == last_c)
								state_q <= ST_DONE;
							else begin
								jl_q    <= ju_q;
								ju_q    <= ju_q + 1'b1;
								state_q <= ST_NXT;
							end
						end
					end
				end
				ST_CKI: state_q <= ST_CKT;
				ST_CKT: begin
					if (item_q.property_req == mti_pkg::PROP_POS ? rd_y_q <= 0 : rd_y_q < 0) begin
						stat_q  <= mti_pkg::STAT_PROP;
						state_q <= ST_DONE;
					end else if (ci_q == last_c)
						state_q <= ST_DONE;
					else begin
						ci_q    <= ci_q + 1'b1;
						state_q <= ST_CKI;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.result_value <= res_q;
						out_q.status       <= stat_q;
						out_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	mti_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.d      (div_d),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_q)
	);

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SR |-> ju_q > jl_q) else $error("search bounds crossed");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV) else $error("divider busy outside divide step");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE) else $error("item from wrong state");
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CKT |-> ci_q != '0) else $error("sign test reached entry zero");

endmodule
`default_nettype wire

/* dv/mti_checker.sv */
// mti_checker: watches the item, result and register channels of the table interpolator,
// predicts every result from its own copy of the table and compares field by field
// depends on mti_pkg only
module mti_checker
	import mti_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire in_item_t              in_item,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire out_item_t             out_item,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint QCAP = longint'(1) << CAP_LOG;

	logic signed [DATA_W-1:0] x_tab [TABLE_DEPTH];
	logic signed [DATA_W-1:0] y_tab [TABLE_DEPTH];
	bit                       tab_mono;
	bit                       y_rising;
	logic [ENT_W-1:0]         n_reg;
	bit                       linear;
	out_item_t                expected_results [$];

	initial begin
		fail_count = 0;
		pending = 0;
		checked = 0;
	end

	function automatic int active_entries();
		int n;
		n = n_reg;
		if (n < 2)
			n = 2;
		if (n > TABLE_DEPTH)
			n = TABLE_DEPTH;
		return n;
	endfunction

	function automatic logic [127:0] mag128(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		return 128'(unsigned'(m));
	endfunction

	// a*b/d rounded half away from zero, capped at 2^40
	function automatic longint scaled_quotient(longint a, longint b, longint d);
		bit neg;
		logic [127:0] ua, ub, ud, q, r;
		neg = ((a < 0) != (b < 0)) != (d < 0);
		ua = mag128(a);
		ub = mag128(b);
		ud = mag128(d);
		if (ua == 0 || ub == 0)
			return 0;
		if (ud == 0) begin
			q = 128'(QCAP);
		end else begin
			q = (ua * ub) / ud;
			r = (ua * ub) % ud;
			if (q >= 128'(QCAP))
				q = 128'(QCAP);
			else if (2 * r >= ud)
				q = q + 1;
		end
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic logic signed [DATA_W-1:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[DATA_W-1:0];
	endfunction

	function automatic longint key_at(bit rev, int i);
		return rev ? longint'(y_tab[i]) : longint'(x_tab[i]);
	endfunction

	function automatic longint val_at(bit rev, int i);
		return rev ? longint'(x_tab[i]) : longint'(y_tab[i]);
	endfunction

	function automatic logic signed [DATA_W-1:0] convert(bit rev, longint q, bit slope);
		int lo_i, hi_i, mid;
		longint k_lo, k_hi, o_lo, o_hi;
		lo_i = 0;
		hi_i = active_entries() - 1;
		while (hi_i - lo_i > 1) begin
			mid = (hi_i + lo_i) >> 1;
			if (q >= key_at(rev, mid))
				lo_i = mid;
			else
				hi_i = mid;
		end
		k_lo = key_at(rev, lo_i);
		k_hi = key_at(rev, hi_i);
		o_lo = val_at(rev, lo_i);
		o_hi = val_at(rev, hi_i);
		if (!linear) begin
			if (slope)
				return '0;
			return clip32(q < k_hi ? o_lo : o_hi);
		end
		if (slope)
			return clip32(scaled_quotient(o_hi - o_lo, longint'(1) << FRAC_BITS, k_hi - k_lo));
		return clip32(o_lo + scaled_quotient(o_hi - o_lo, q - k_lo, k_hi - k_lo));
	endfunction

	function automatic logic signed [DATA_W-1:0] seg_slope(int i);
		return clip32(scaled_quotient(longint'(y_tab[i]) - longint'(y_tab[i-1]),
			longint'(1) << FRAC_BITS, longint'(x_tab[i]) - longint'(x_tab[i-1])));
	endfunction

	function automatic logic [1:0] check_property(logic [1:0] prop);
		int n;
		logic signed [DATA_W-1:0] s, s_next;
		n = active_entries();
		case (prop)
			PROP_POS: begin
				for (int i = 1; i < n; i++)
					if (y_tab[i] <= 0)
						return STAT_PROP;
				return STAT_OK;
			end
			PROP_NONNEG: begin
				for (int i = 1; i < n; i++)
					if (y_tab[i] < 0)
						return STAT_PROP;
				return STAT_OK;
			end
			PROP_STRICT: return y_rising ? STAT_OK : STAT_PROP;
			default: begin
				s = seg_slope(1);
				for (int i = 2; i < n; i++) begin
					s_next = seg_slope(i);
					if (s_next < s)
						return STAT_PROP;
					s = s_next;
				end
				return STAT_OK;
			end
		endcase
	endfunction

	function automatic out_item_t predict(in_item_t it);
		out_item_t res;
		int idx;
		res = '0;
		idx = it.entry_index;
		if (it.func == FUNC_LOAD) begin
			x_tab[idx] = it.x_value;
			y_tab[idx] = it.y_value;
			if (idx == 0) begin
				tab_mono = 1;
				y_rising = 1;
			end else begin
				if (it.x_value <= x_tab[idx-1] || it.y_value < y_tab[idx-1])
					tab_mono = 0;
				if (it.y_value == y_tab[idx-1])
					y_rising = 0;
			end
			res.status = tab_mono ? STAT_OK : STAT_NOT_MONO;
		end else if (it.func <= FUNC_CHECK) begin
			if (!tab_mono)
				res.status = STAT_NOT_MONO;
			else if (it.func == FUNC_FWD || it.func == FUNC_FWD_SLOPE)
				res.result_value = convert(0, longint'(it.query_value), it.func == FUNC_FWD_SLOPE);
			else if (it.func == FUNC_REV || it.func == FUNC_REV_SLOPE) begin
				if (!y_rising)
					res.status = STAT_NOT_REV;
				else
					res.result_value = convert(1, longint'(it.query_value),
						it.func == FUNC_REV_SLOPE);
			end else
				res.status = check_property(it.property_req);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			expected_results.delete();
			tab_mono = 1;
			y_rising = 1;
			n_reg = 2;
			linear = 1;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				checked++;
				if (expected_results.size() == 0) begin
					$error("result item with none expected: result_value %0d status %0d",
						out_item.result_value, out_item.status);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_item.result_value !== want.result_value) begin
						$error("result_value: expected %0d, got %0d",
							want.result_value, out_item.result_value);
						fail_count++;
					end
					if (out_item.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_item.status);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ENTRIES)
					n_reg = cfg_data;
				else
					linear = cfg_data[0];
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict(in_item));
			pending = expected_results.size();
		end
	end

endmodule

/* dv/tb_monotone_table_interpolator_core.sv */
// tb_monotone_table_interpolator_core: stimulus and verdict for the table interpolator
// loads breakpoint tables, sweeps register settings and sends random queries and checks
// depends on mti_pkg, mti_checker and the core rtl
module tb_monotone_table_interpolator_core;
	import mti_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     LIMIT        = 20_000_000;
	localparam int     N_PHASES     = 14;
	localparam int     PHASE_ITEMS  = 80;
	localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
	localparam int     TBL_CLEAN    = 0;
	localparam int     TBL_FLAT     = 1;
	localparam int     TBL_BROKEN   = 2;
	localparam int     TBL_CONVEX   = 3;
	localparam int     TBL_SPAN     = 4;
	localparam longint Q_MIN        = -64'sd2147483648;
	localparam longint Q_MAX        = 64'sd2147483647;
	localparam longint SPAN_STEP    = 64'sd286331153;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int     fail_count, pending, checked;
	int     idle_pct = 37;
	int     cycles = 0;
	int     items_sent = 0;
	int     reg_writes = 0;
	longint tx [TABLE_DEPTH];
	longint ty [TABLE_DEPTH];

	monotone_table_interpolator_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	mti_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send(input in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic in_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	function automatic in_item_t mk(logic [2:0] f, int idx, longint xv, longint yv, longint qv,
		logic [1:0] prop);
		in_item_t it;
		it.func = f;
		it.entry_index = 4'(idx);
		it.x_value = 32'(xv);
		it.y_value = 32'(yv);
		it.query_value = 32'(qv);
		it.property_req = prop;
		return it;
	endfunction

	function automatic void build_table(int kind);
		int sx, sy, p;
		sx = $urandom_range(2, 26);
		sy = $urandom_range(0, 26);
		tx[0] = -longint'($urandom_range(0, 32'h4000_0000));
		ty[0] = longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000;
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			if (kind == TBL_CONVEX) begin
				tx[i] = tx[i-1] + (longint'(1) << sx);
				ty[i] = ty[i-1] + i * longint'($urandom_range(0, 1 << (sy > 20 ? 20 : sy)));
			end else begin
				tx[i] = tx[i-1] + longint'($urandom_range(1, 1 << sx));
				ty[i] = ty[i-1] + longint'($urandom_range(1, 1 << sy));
			end
		end
		if (kind == TBL_SPAN) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				tx[i] = Q_MIN + i * SPAN_STEP;
				ty[i] = Q_MIN + i * SPAN_STEP;
			end
		end
		p = $urandom_range(1, TABLE_DEPTH - 1);
		if (kind == TBL_FLAT)
			ty[p] = ty[p-1];
		else if (kind == TBL_BROKEN) begin
			if ($urandom_range(0, 1))
				tx[p] = tx[p-1];
			else
				ty[p] = ty[p-1] - 1;
		end
	endfunction

	task automatic load_table();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send(mk(FUNC_LOAD, i, tx[i], ty[i], longint'($urandom), 2'($urandom)));
	endtask

	function automatic longint pick_query(bit rev);
		int i;
		longint k0, k1;
		i = $urandom_range(0, TABLE_DEPTH - 2);
		k0 = rev ? ty[i] : tx[i];
		k1 = rev ? ty[i+1] : tx[i+1];
		case ($urandom_range(0, 4))
			0: return longint'($urandom);
			1: return k0;
			2: return k0 + longint'($urandom_range(0, 8)) - 4;
			3: return (k0 + k1) / 2;
			default: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int r, i;
		it.entry_index = 4'($urandom);
		it.x_value = $urandom;
		it.y_value = $urandom;
		it.query_value = $urandom;
		it.property_req = 2'($urandom);
		r = $urandom_range(0, 99);
		if (r < 30) begin
			it.func = FUNC_FWD;
			it.query_value = 32'(pick_query(0));
		end else if (r < 55) begin
			it.func = FUNC_REV;
			it.query_value = 32'(pick_query(1));
		end else if (r < 63) begin
			it.func = FUNC_FWD_SLOPE;
			it.query_value = 32'(pick_query(0));
		end else if (r < 71) begin
			it.func = FUNC_REV_SLOPE;
			it.query_value = 32'(pick_query(1));
		end else if (r < 83) begin
			it.func = FUNC_CHECK;
		end else if (r < 96) begin
			it.func = FUNC_LOAD;
			i = it.entry_index;
			if ($urandom_range(0, 19) != 0) begin
				it.x_value = 32'(tx[i]);
				it.y_value = 32'(ty[i]);
			end else begin
				tx[i] = longint'(it.x_value);
				ty[i] = longint'(it.y_value);
			end
		end else begin
			it.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
		end
		return it;
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] n_sel;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// two-entry table across the full range, then broken and flat tables
		send(mk(FUNC_LOAD, 0, Q_MIN, Q_MIN, 0, PROP_POS));
		send(mk(FUNC_LOAD, 1, Q_MAX, Q_MAX, 0, PROP_POS));
		send(mk(FUNC_FWD, 0, 0, 0, Q_MIN, PROP_POS));
		send(mk(FUNC_FWD, 0, 0, 0, Q_MAX, PROP_POS));
		send(mk(FUNC_FWD, 0, 0, 0, 0, PROP_POS));
		send(mk(FUNC_REV, 0, 0, 0, 0, PROP_POS));
		send(mk(FUNC_FWD_SLOPE, 0, 0, 0, 7, PROP_POS));
		send(mk(FUNC_REV_SLOPE, 0, 0, 0, -7, PROP_POS));
		send(mk(FUNC_CHECK, 0, 0, 0, 0, PROP_POS));
		send(mk(FUNC_CHECK, 0, 0, 0, 0, PROP_NONNEG));
		send(mk(FUNC_CHECK, 0, 0, 0, 0, PROP_STRICT));
		send(mk(FUNC_CHECK, 0, 0, 0, 0, PROP_SLOPE_UP));
		send(mk(FUNC_SPARE_LO, 15, -1, -1, -1, PROP_SLOPE_UP));
		send(mk(FUNC_SPARE_HI, 15, -1, -1, -1, PROP_SLOPE_UP));
		send(mk(FUNC_LOAD, 2, Q_MAX, Q_MAX, 0, PROP_POS));
		send(mk(FUNC_FWD, 0, 0, 0, 5, PROP_POS));
		send(mk(FUNC_CHECK, 0, 0, 0, 0, PROP_NONNEG));
		send(mk(FUNC_LOAD, 0, 0, -5, 0, PROP_POS));
		send(mk(FUNC_LOAD, 1, 10, -5, 0, PROP_POS));
		send(mk(FUNC_REV, 0, 0, 0, -5, PROP_POS));
		send(mk(FUNC_REV_SLOPE, 0, 0, 0, -5, PROP_POS));
		send(mk(FUNC_FWD, 0, 0, 0, -100, PROP_POS));
		send(mk(FUNC_FWD_SLOPE, 0, 0, 0, 3, PROP_POS));
		send(mk(FUNC_CHECK, 0, 0, 0, 0, PROP_STRICT));
		in_quiet();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// hold off until every result is back before touching registers
			idle_pct = 37;
			drain();
			case (ph)
				0: n_sel = CFG_DATA_W'(16);
				1: n_sel = CFG_DATA_W'(2);
				2: n_sel = CFG_DATA_W'(0);
				3: n_sel = CFG_DATA_W'(31);
				4: n_sel = CFG_DATA_W'(1);
				5: n_sel = CFG_DATA_W'(17);
				default: n_sel = CFG_DATA_W'($urandom_range(2, 16));
			endcase
			write_reg(CFG_ENTRIES, n_sel);
			write_reg(CFG_MODE, ph < 4 ? CFG_DATA_W'(ph % 2) :
				CFG_DATA_W'($urandom_range(0, 3) != 0));
			build_table((ph == 0 || ph == 7) ? TBL_SPAN : $urandom_range(TBL_CLEAN, TBL_CONVEX));
			if (ph == 5)
				idle_pct = 0;
			load_table();
			repeat (PHASE_ITEMS) send(random_item());
			in_quiet();
		end

		idle_pct = 37;
		drain();
		repeat (300) @(negedge clk);
		$display("ran %0d items and %0d register writes over %0d table settings;", items_sent,
			reg_writes, N_PHASES);
		$display("compared %0d results across both lookup modes and all operations", checked);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
